// ===== src/c8fd_pkg.sv =====
// Shared constants for the CRC-8 framed byte receiver.
// No dependencies; used by crc8_frame_deframer_core.
`default_nettype none

package c8fd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned M_DATA_W = 24;

  // Result capacity of one frame.
  localparam int unsigned RESULT_CAP = 64;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic [7:0]       START_MARKER_RST = 8'd170;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST   = 7'd64;

  // Configuration register indexes.
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

endpackage

`default_nettype wire

// ===== src/crc8_frame_deframer_core.sv =====
// Top level of the CRC-8 framed byte receiver: parser, bit-serial CRC unit,
// body store and readout. Depends on c8fd_pkg.
`default_nettype none

// Receives bytes on the s_ side, one item at a time. In hunting, for a
// rejected length byte and while waiting for the CRC byte an item is taken
// without a CRC shift run. An accepted length byte or a body byte is taken,
// then run through eight steps of the shared bit-serial CRC-8 shift unit
// (polynomial 0x07, initial value 0), during which s_tready is low. When the
// CRC byte matches, the stored body is read out of the body memory byte by
// byte, each as a registered read and then the output item, which waits while
// m_tready is low; input is stalled until the last byte (m_tlast) is taken. A
// mismatching frame is dropped with no output. The body memory needs no
// clearing after reset.
module crc8_frame_deframer_core #(
  parameter int unsigned MAX_BODY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Received bytes.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [c8fd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
  // Accepted frame body.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [c8fd_pkg::M_DATA_W-1:0]      m_tdata,   // [7:0] payload_byte,
                                                        // [13:8] byte_position,
                                                        // [20:14] frame_length,
                                                        // [23:21] zero
  output logic                               m_tlast,
  // Configuration writes.
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [c8fd_pkg::CFG_W-1:0]    cfg_data
);

  localparam int unsigned DEPTH  = (MAX_BODY < c8fd_pkg::RESULT_CAP) ?
                                   MAX_BODY : c8fd_pkg::RESULT_CAP;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [c8fd_pkg::LEN_W-1:0] DEPTH_L = c8fd_pkg::LEN_W'(DEPTH);

  typedef enum logic [2:0] {
    S_HUNT,
    S_LEN,
    S_BODY,
    S_CHECK,
    S_CRC_RUN,
    S_READ,
    S_SEND
  } state_t;

  state_t                       state;
  logic [7:0]                   start_marker;
  logic [c8fd_pkg::LEN_W-1:0]   max_length;
  logic [c8fd_pkg::LEN_W-1:0]   body_length;
  logic [c8fd_pkg::LEN_W-1:0]   byte_count;
  logic [7:0]                   running_crc;
  logic [2:0]                   bit_cnt;
  logic [7:0]                   rd_data;
  logic [7:0]                   body_store [DEPTH];

  logic [c8fd_pkg::LEN_W-1:0]   limit;
  logic                         in_take;
  logic                         len_ok;
  logic [c8fd_pkg::LEN_W-1:0]   count_inc;
  logic                         out_last;
  logic [7:0]                   crc_shift;

  assign limit     = (max_length < DEPTH_L) ? max_length : DEPTH_L;
  assign len_ok    = (s_tdata != 8'd0) && (s_tdata <= {1'b0, limit});
  assign count_inc = byte_count + 1'b1;
  assign out_last  = (count_inc == body_length);

  // One step of the shared CRC shift unit.
  assign crc_shift = running_crc[7] ? ({running_crc[6:0], 1'b0} ^ c8fd_pkg::CRC_POLY)
                                    : {running_crc[6:0], 1'b0};

  assign s_tready = (state == S_HUNT) || (state == S_LEN) ||
                    (state == S_BODY) || (state == S_CHECK);
  assign in_take  = s_tvalid && s_tready;

  assign m_tvalid = (state == S_SEND);
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, body_length, byte_count[c8fd_pkg::POS_W-1:0], rd_data};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= c8fd_pkg::START_MARKER_RST;
      max_length   <= c8fd_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        c8fd_pkg::REG_START_MARKER: start_marker <= cfg_data;
        c8fd_pkg::REG_MAX_LENGTH:   max_length   <= cfg_data[c8fd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Body memory: written while the body arrives, read during readout.
  always_ff @(posedge clk) begin
    if (in_take && (state == S_BODY)) begin
      body_store[byte_count[ADDR_W-1:0]] <= s_tdata;
    end
    if (state == S_READ) begin
      rd_data <= body_store[byte_count[ADDR_W-1:0]];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_HUNT;
      body_length <= '0;
      byte_count  <= '0;
      running_crc <= c8fd_pkg::CRC_INIT;
      bit_cnt     <= '0;
    end else begin
      case (state)
        S_HUNT: begin
          if (in_take && (s_tdata == start_marker)) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (in_take) begin
            if (len_ok) begin
              body_length <= s_tdata[c8fd_pkg::LEN_W-1:0];
              byte_count  <= '0;
              running_crc <= c8fd_pkg::CRC_INIT ^ s_tdata;
              bit_cnt     <= '0;
              state       <= S_CRC_RUN;
            end else begin
              state <= S_HUNT;
            end
          end
        end
        S_BODY: begin
          if (in_take) begin
            running_crc <= running_crc ^ s_tdata;
            byte_count  <= count_inc;
            bit_cnt     <= '0;
            state       <= S_CRC_RUN;
          end
        end
        S_CRC_RUN: begin
          running_crc <= crc_shift;
          bit_cnt     <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= (byte_count >= body_length) ? S_CHECK : S_BODY;
          end
        end
        S_CHECK: begin
          if (in_take) begin
            if (s_tdata == running_crc) begin
              byte_count <= '0;
              state      <= S_READ;
            end else begin
              state <= S_HUNT;
            end
          end
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (m_tready) begin
            if (out_last) begin
              state <= S_HUNT;
            end else begin
              byte_count <= count_inc;
              state      <= S_READ;
            end
          end
        end
        default: begin
          state <= S_HUNT;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Input and output sides are never open at the same time.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output handshakes open together");

  // Readout never runs past the stored body.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (byte_count < body_length) && (body_length <= DEPTH_L))
    else $error("readout index beyond frame body");

  // The CRC unit only counts while it is shifting.
  a_bit_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_CRC_RUN) |-> (bit_cnt == 3'd0) || ($past(state) == S_CRC_RUN))
    else $error("CRC shift count active outside a shift run");

  // A shift run always ends after eight steps.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRC_RUN) && (bit_cnt == 3'd7) |=> (state == S_BODY) || (state == S_CHECK))
    else $error("CRC shift run did not end after eight steps");

  // An accepted length is never zero and never above the store depth.
  a_len_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_BODY) |-> (body_length != '0) && (body_length <= DEPTH_L))
    else $error("body length out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_crc8_frame_deframer_core.sv =====
// Self-checking testbench for crc8_frame_deframer_core: directed frames, then
// randomized framed traffic under several marker and length settings.
// Depends on c8fd_pkg and the core RTL only.
`default_nettype none

module tb_crc8_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BODY     = 64;
  localparam int unsigned DRAIN_CYCLES = 32;

  typedef enum logic [1:0] {
    HUNT,
    GET_LEN,
    GET_BODY,
    GET_CRC
  } rx_phase_t;

  typedef struct packed {
    logic [c8fd_pkg::BYTE_W-1:0] payload;
    logic [c8fd_pkg::POS_W-1:0]  pos;
    logic [c8fd_pkg::LEN_W-1:0]  len;
    logic                        is_last;
  } body_rec_t;

  typedef enum {
    ROW_NONE,
    ROW_ONE,
    ROW_CRC,
    ROW_BADCRC
  } row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [c8fd_pkg::BYTE_W-1:0] rx;
    body_rec_t                   want;
  } stim_row_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [c8fd_pkg::BYTE_W-1:0]   s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [c8fd_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tlast;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [c8fd_pkg::CFG_W-1:0]    cfg_data;

  crc8_frame_deframer_core #(
    .MAX_BODY(MAX_BODY)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the receiver state and registers.
  logic [7:0]                 cur_marker;
  logic [c8fd_pkg::LEN_W-1:0] cur_max_len;
  rx_phase_t                  ph;
  logic [c8fd_pkg::LEN_W-1:0] body_len;
  logic [c8fd_pkg::LEN_W-1:0] body_cnt;
  logic [7:0]                 run_crc;
  logic [7:0]                 body_mem [MAX_BODY];

  body_rec_t pending_body_q [$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned sent_items;
  int unsigned frames_ok;
  int unsigned frames_bad_crc;
  bit          steady;

  stim_row_t dir_tab [25] = '{
    '{ROW_NONE,   8'h00, '0},
    '{ROW_NONE,   8'hFF, '0},
    '{ROW_NONE,   8'hAA, '0},
    '{ROW_NONE,   8'h00, '0},   // zero length aborts
    '{ROW_NONE,   8'hAA, '0},
    '{ROW_NONE,   8'h41, '0},   // one above the limit aborts
    '{ROW_NONE,   8'hAA, '0},
    '{ROW_NONE,   8'h01, '0},
    '{ROW_NONE,   8'h00, '0},
    '{ROW_ONE,    8'h15, '{8'h00, 6'd0, 7'd1, 1'b1}},
    '{ROW_NONE,   8'hAA, '0},
    '{ROW_NONE,   8'h01, '0},
    '{ROW_NONE,   8'hFF, '0},
    '{ROW_CRC,    8'h00, '0},
    '{ROW_NONE,   8'hAA, '0},
    '{ROW_NONE,   8'h03, '0},
    '{ROW_NONE,   8'hAA, '0},   // marker inside the body is plain data
    '{ROW_NONE,   8'h00, '0},
    '{ROW_NONE,   8'hFF, '0},
    '{ROW_CRC,    8'h00, '0},
    '{ROW_NONE,   8'hAA, '0},
    '{ROW_NONE,   8'h02, '0},
    '{ROW_NONE,   8'h12, '0},
    '{ROW_NONE,   8'h34, '0},
    '{ROW_BADCRC, 8'h00, '0}
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ c8fd_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic int len_limit();
    int lim;
    lim = cur_max_len;
    if (lim > MAX_BODY) lim = MAX_BODY;
    if (lim > c8fd_pkg::RESULT_CAP) lim = c8fd_pkg::RESULT_CAP;
    return lim;
  endfunction

  // Advances the shadow receiver by one byte; queues the body when the CRC matches and keep is set.
  task automatic deframe_byte(input logic [7:0] b, input bit keep);
    body_rec_t r;
    case (ph)
      HUNT: begin
        if (b == cur_marker) ph = GET_LEN;
      end
      GET_LEN: begin
        if (b == 8'd0 || int'(b) > len_limit()) begin
          ph = HUNT;
        end else begin
          body_len = b[c8fd_pkg::LEN_W-1:0];
          body_cnt = '0;
          run_crc  = crc8_update(c8fd_pkg::CRC_INIT, b);
          ph       = GET_BODY;
        end
      end
      GET_BODY: begin
        if (body_cnt < body_len) begin
          body_mem[body_cnt[c8fd_pkg::POS_W-1:0]] = b;
          run_crc  = crc8_update(run_crc, b);
          body_cnt = body_cnt + 1'b1;
        end
        if (body_cnt >= body_len) ph = GET_CRC;
      end
      default: begin
        if (b == run_crc) begin
          frames_ok++;
          if (keep) begin
            for (int i = 0; i < body_len; i++) begin
              r.payload = body_mem[i[c8fd_pkg::POS_W-1:0]];
              r.pos     = i[c8fd_pkg::POS_W-1:0];
              r.len     = body_len;
              r.is_last = (i + 1 == body_len);
              pending_body_q.push_back(r);
            end
          end
        end else begin
          frames_bad_crc++;
        end
        ph = HUNT;
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("mismatch on %s of result %0d: got 0x%0h, expected 0x%0h",
             field, results_seen, got, want);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit keep);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 35) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    sent_items++;
    deframe_byte(b, keep);
  endtask

  task automatic write_reg(input logic idx, input logic [c8fd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == c8fd_pkg::REG_START_MARKER) cur_marker = val;
    else cur_max_len = val[c8fd_pkg::LEN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Holds the input off until every queued body byte has come out.
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_body_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_crc(input bit good);
    logic [7:0] flip;
    flip = good ? 8'h00 : (8'h01 << $urandom_range(0, 7));
    send_byte(run_crc ^ flip, 1'b1);
  endtask

  // Mostly short bodies; now and then one at the full limit.
  task automatic send_frame();
    int cap;
    int len;
    cap = (len_limit() == 0) ? 8 : len_limit();
    if ($urandom_range(0, 11) == 0) len = cap;
    else len = $urandom_range(1, (cap < 8) ? cap : 8);
    send_byte(cur_marker, 1'b1);
    send_byte(len[7:0], 1'b1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_byte(cur_marker, 1'b1);
      else send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    send_crc($urandom_range(0, 5) != 0);
  endtask

  task automatic send_noise();
    int len;
    case ($urandom_range(0, 3))
      0: send_byte(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_byte(cur_marker, 1'b1);
        send_byte(8'h00, 1'b1);
      end
      2: begin
        send_byte(cur_marker, 1'b1);
        send_byte(8'($urandom_range(len_limit() + 1, 255)), 1'b1);
      end
      default: begin
        // Truncated frame: whatever follows is taken as its body.
        len = $urandom_range(2, 8);
        send_byte(cur_marker, 1'b1);
        send_byte(len[7:0], 1'b1);
        repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  task automatic run_phase(input logic [7:0] marker,
                           input logic [c8fd_pkg::CFG_W-1:0] max_len,
                           input int unsigned quota, input bit no_idle);
    int unsigned target;
    wait_drain();
    write_reg(c8fd_pkg::REG_START_MARKER, marker);
    write_reg(c8fd_pkg::REG_MAX_LENGTH, max_len);
    steady = no_idle;
    target = sent_items + quota;
    while (sent_items < target) begin
      if ($urandom_range(0, 99) < 85) send_frame();
      else send_noise();
      if ($urandom_range(0, 24) == 0) wait_drain();
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready = steady || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    body_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_body_q.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = pending_body_q.pop_front();
        if (m_tdata[7:0] !== want.payload)
          report_mismatch("payload_byte", int'(m_tdata[7:0]), int'(want.payload));
        if (m_tdata[13:8] !== want.pos)
          report_mismatch("byte_position", int'(m_tdata[13:8]), int'(want.pos));
        if (m_tdata[20:14] !== want.len)
          report_mismatch("frame_length", int'(m_tdata[20:14]), int'(want.len));
        if (m_tlast !== want.is_last)
          report_mismatch("last", int'(m_tlast), int'(want.is_last));
      end
      results_seen++;
    end
  end

  initial begin
    #5_000_000;
    $display("tb_crc8_frame_deframer_core: FAIL");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = c8fd_pkg::REG_START_MARKER;
    cfg_data       = '0;
    steady         = 1'b0;
    errors         = 0;
    results_seen   = 0;
    sent_items     = 0;
    frames_ok      = 0;
    frames_bad_crc = 0;
    cur_marker     = c8fd_pkg::START_MARKER_RST;
    cur_max_len    = c8fd_pkg::MAX_LENGTH_RST;
    ph             = HUNT;
    body_len       = '0;
    body_cnt       = '0;
    run_crc        = c8fd_pkg::CRC_INIT;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_NONE:   send_byte(dir_tab[i].rx, 1'b0);
        ROW_ONE: begin
          send_byte(dir_tab[i].rx, 1'b0);
          pending_body_q.push_back(dir_tab[i].want);
        end
        ROW_CRC:    send_byte(run_crc, 1'b1);
        default:    send_byte(run_crc ^ 8'h01, 1'b0);
      endcase
    end

    run_phase(8'h00, 8'd1, 60, 1'b0);
    run_phase(8'hFF, 8'd127, 70, 1'b1);
    run_phase(8'h5A, 8'd0, 20, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'hC0, 70, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(2, 63)), 70, 1'b0);
    run_phase(c8fd_pkg::START_MARKER_RST, 8'(c8fd_pkg::MAX_LENGTH_RST), 70, 1'b0);

    wait_drain();
    $display("Sent %0d bytes over six marker/limit settings and checked %0d body bytes.",
             sent_items, results_seen);
    $display("Frames delivered: %0d, frames dropped on CRC mismatch: %0d.",
             frames_ok, frames_bad_crc);
    if (errors == 0) begin
      $display("tb_crc8_frame_deframer_core: PASS");
    end else begin
      $display("tb_crc8_frame_deframer_core: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== crc8_frame_deframer_core.f =====
src/c8fd_pkg.sv
src/crc8_frame_deframer_core.sv
verif/tb_crc8_frame_deframer_core.sv
